>>> src/yuyv_to_rgb_bottom_up_core_defines.svh
// Assertion macros for the YUYV to BGR converter core.
// Uses the clk and arst_n names of the module that includes this header.
`ifndef YUYV_TO_RGB_BOTTOM_UP_CORE_DEFINES_SVH
`define YUYV_TO_RGB_BOTTOM_UP_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define Y2R_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define Y2R_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/yuyv2rgb_pkg.sv
// Shared types, register indexes and helper functions for the YUYV to BGR core.
// No dependencies.
package yuyv2rgb_pkg;

	localparam int unsigned MaxWidth  = 4096;
	localparam int unsigned MaxHeight = 4096;

	localparam int unsigned CfgW   = 13;
	localparam int unsigned ColW   = 14;
	localparam int unsigned RowW   = 12;
	localparam int unsigned AddrW  = 26;
	localparam int unsigned AccW   = 20;

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} bgr_t;

	// Even width clamped to 2..MaxWidth, times three bytes per pixel.
	function automatic logic [ColW-1:0] line_bytes(input logic [CfgW-1:0] width);
		logic [CfgW-1:0] w;
		w = {width[CfgW-1:1], 1'b0};
		if (w < CfgW'(2))
			w = CfgW'(2);
		else if (w > CfgW'(MaxWidth))
			w = CfgW'(MaxWidth);
		return ({1'b0, w} << 1) + {1'b0, w};
	endfunction

	function automatic logic [CfgW-1:0] eff_height(input logic [CfgW-1:0] height);
		logic [CfgW-1:0] h;
		h = height;
		if (h < CfgW'(1))
			h = CfgW'(1);
		else if (h > CfgW'(MaxHeight))
			h = CfgW'(MaxHeight);
		return h;
	endfunction

	// Drop the Q8 fraction (floor) and saturate to 0..255.
	function automatic logic [7:0] q8_sat(input logic signed [AccW-1:0] acc);
		logic signed [AccW-1:0] q;
		q = acc >>> 8;
		if (q < 0)
			return 8'd0;
		else if (q > AccW'(255))
			return 8'd255;
		else
			return q[7:0];
	endfunction

endpackage

>>> src/yuyv2rgb_pixel.sv
// One-pixel BT.601 studio-range YCbCr to BGR converter, Q8 coefficients.
// Depends on yuyv2rgb_pkg.
module yuyv2rgb_pixel
	import yuyv2rgb_pkg::*;
(
	input  logic [7:0] luma,
	input  logic [7:0] cb,
	input  logic [7:0] cr,
	output bgr_t       pixel
);

	logic signed [AccW-1:0] c, d, e, yterm;
	logic signed [AccW-1:0] acc_b, acc_g, acc_r;

	always_comb begin
		c     = $signed({{(AccW-8){1'b0}}, luma}) - AccW'(16);
		d     = $signed({{(AccW-8){1'b0}}, cb}) - AccW'(128);
		e     = $signed({{(AccW-8){1'b0}}, cr}) - AccW'(128);
		yterm = AccW'(298) * c + AccW'(128);
		acc_b = yterm + AccW'(516) * d;
		acc_g = yterm - AccW'(100) * d - AccW'(208) * e;
		acc_r = yterm + AccW'(409) * e;
		pixel.blue  = q8_sat(acc_b);
		pixel.green = q8_sat(acc_g);
		pixel.red   = q8_sat(acc_r);
	end

endmodule

>>> src/yuyv_to_rgb_bottom_up_core.sv
// Top level of the YUYV macropixel to BGR888 converter for bottom-up bitmaps.
// Depends on yuyv2rgb_pkg, yuyv2rgb_pixel and the core defines header.
`include "yuyv_to_rgb_bottom_up_core_defines.svh"

// Takes one YUYV macropixel per beat and returns two BGR pixels, the byte address
// of the first pixel in a bottom-up BGR frame buffer, and tlast on the frame's
// last macropixel, after which the column and row counters wrap. Throughput is one
// macropixel per clock while m_tready is high; an input register holds the counter
// results, then the color math and the address multiply feed the output register.
// Set image_width and image_height only while the core is empty; counters keep
// their value across a write.
module yuyv_to_rgb_bottom_up_core
	import yuyv2rgb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CfgW-1:0]  cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	// luma_first, chroma_blue, luma_second, chroma_red (8 bits each, from bit 0)
	input  logic [31:0]      s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// blue_first, green_first, red_first, blue_second, green_second, red_second
	// (8 bits each), byte_offset (26), zero fill (6), from bit 0
	output logic [79:0]      m_tdata,
	output logic             m_tlast
);

	logic [CfgW-1:0] width_q, height_q;
	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;

	logic [ColW-1:0] lb_c;
	logic [CfgW-1:0] h_c;
	logic            line_end_c, last_c;
	logic [RowW-1:0] flip_c;
	logic            s_acc, adv_s1;

	logic            valid_s1;
	logic [31:0]     data_s1;
	logic [RowW-1:0] flip_s1;
	logic [ColW-1:0] lb_s1, col_s1;
	logic            last_s1;

	bgr_t            px0_c, px1_c;
	logic [AddrW-1:0] offset_c;

	logic            valid_s2;
	bgr_t            px0_s2, px1_s2;
	logic [AddrW-1:0] offset_s2;
	logic            last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CfgW'(640);
			height_q <= CfgW'(480);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		lb_c       = line_bytes(width_q);
		h_c        = eff_height(height_q);
		line_end_c = ({1'b0, col_q} + (ColW+1)'(6)) >= {1'b0, lb_c};
		last_c     = line_end_c && (({1'b0, row_q} + CfgW'(1)) >= h_c);
		// a row past the last line addresses flipped row zero
		if ({1'b0, row_q} < h_c)
			flip_c = RowW'(h_c - CfgW'(1) - {1'b0, row_q});
		else
			flip_c = '0;
	end

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_acc) begin
			if (last_c) begin
				col_q <= '0;
				row_q <= '0;
			end else if (line_end_c) begin
				col_q <= '0;
				row_q <= row_q + RowW'(1);
			end else begin
				col_q <= col_q + ColW'(6);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			data_s1 <= s_tdata;
			flip_s1 <= flip_c;
			lb_s1   <= lb_c;
			col_s1  <= col_q;
			last_s1 <= last_c;
		end
	end

	yuyv2rgb_pixel u_px0 (
		.luma  (data_s1[7:0]),
		.cb    (data_s1[15:8]),
		.cr    (data_s1[31:24]),
		.pixel (px0_c)
	);

	yuyv2rgb_pixel u_px1 (
		.luma  (data_s1[23:16]),
		.cb    (data_s1[15:8]),
		.cr    (data_s1[31:24]),
		.pixel (px1_c)
	);

	assign offset_c = ({{(AddrW-RowW){1'b0}}, flip_s1} * {{(AddrW-ColW){1'b0}}, lb_s1})
		+ {{(AddrW-ColW){1'b0}}, col_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (!valid_s2 || m_tready)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			px0_s2    <= px0_c;
			px1_s2    <= px1_c;
			offset_s2 <= offset_c;
			last_s2   <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = last_s2;
	assign m_tdata  = {6'd0, offset_s2,
		px1_s2.red, px1_s2.green, px1_s2.blue,
		px0_s2.red, px0_s2.green, px0_s2.blue};

	`Y2R_ASSERT_NEXT(a_frame_wrap, s_acc && last_c, col_q == '0 && row_q == '0,
		"counters did not wrap after the last macropixel")
	`Y2R_ASSERT_NEXT(a_col_step, s_acc && !line_end_c, col_q == $past(col_q) + ColW'(6),
		"column did not advance by one macropixel")
	`Y2R_ASSERT_NEXT(a_s1_moves, adv_s1, valid_s2, "result lost between stages")
	`Y2R_ASSERT_NOW(a_hold_idle, !s_acc && !cfg_we && !valid_s1 && !valid_s2, s_tready,
		"empty core refused input")

endmodule
